/* sv/corov_pkg.sv */
package corov_pkg;

  localparam int CoordBits    = 16;
  localparam int TrigFracBits = 15;
  localparam int AngleBits    = 16;
  localparam int CordicSteps  = 16;
  localparam int StepBits     = 4;
  localparam int ZBits        = 34;
  localparam int XyBits       = 20;
  localparam int TrigBits     = TrigFracBits + 1;
  localparam int DiffBits     = CoordBits + 1;
  localparam int ProdBits     = DiffBits + TrigBits + 1;
  localparam int LocBits      = ProdBits - (TrigFracBits - 2) + 1;
  localparam int SqBits       = 2 * LocBits + 1;
  localparam int RadBits      = CoordBits - 1;

  localparam logic [31:0] GainQ32 = 32'd2608131496;
  localparam logic [XyBits-1:0] CordicX0 =
    XyBits'((64'(GainQ32) + (64'd1 << (31 - TrigFracBits))) >> (32 - TrigFracBits));

  typedef logic signed [XyBits-1:0] xy_t;
  typedef logic signed [ZBits-1:0]  z_t;
  typedef logic signed [DiffBits-1:0] diff_t;

  // stage payload carried alongside the cordic
  typedef struct packed {
    diff_t                dx;
    diff_t                dy;
    logic [RadBits-1:0]   rad;
    logic [RadBits-1:0]   w;
    logic [RadBits-1:0]   h;
    logic [1:0]           quad;
  } geom_t;

  function automatic logic [31:0] atan_turn(input int i);
    logic [31:0] t;
    case (i)
      0: t = 32'd536870912;  1: t = 32'd316933406;  2: t = 32'd167458907;
      3: t = 32'd85004756;   4: t = 32'd42667331;   5: t = 32'd21354465;
      6: t = 32'd10679838;   7: t = 32'd5340245;    8: t = 32'd2670163;
      9: t = 32'd1335087;    10: t = 32'd667544;    11: t = 32'd333772;
      12: t = 32'd166886;    13: t = 32'd83443;     14: t = 32'd41722;
      15: t = 32'd20861;
      default: t = 32'd0;
    endcase
    return t;
  endfunction

endpackage

/* sv/corov_cordic_stage.sv */
// one cordic rotation step, registered, with stall
module corov_cordic_stage (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                en_i,
  input  logic [corov_pkg::StepBits-1:0] step_i,
  input  logic                valid_i,
  input  corov_pkg::xy_t      x_i,
  input  corov_pkg::xy_t      y_i,
  input  corov_pkg::z_t       z_i,
  input  corov_pkg::geom_t    geom_i,
  output logic                valid_o,
  output corov_pkg::xy_t      x_o,
  output corov_pkg::xy_t      y_o,
  output corov_pkg::z_t       z_o,
  output corov_pkg::geom_t    geom_o
);
  corov_pkg::xy_t x_d, y_d, xs, ys, x_q, y_q;
  corov_pkg::z_t  z_d, z_q, at;
  corov_pkg::geom_t geom_q;
  logic valid_q;

  // rotate toward zero residual angle
  always_comb begin
    xs = x_i >>> step_i;
    ys = y_i >>> step_i;
    at = corov_pkg::z_t'({2'b00, corov_pkg::atan_turn(int'(step_i))});
    if (!z_i[corov_pkg::ZBits-1]) begin
      x_d = x_i - ys; y_d = y_i + xs; z_d = z_i - at;
    end else begin
      x_d = x_i + ys; y_d = y_i - xs; z_d = z_i + at;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      x_q <= x_d; y_q <= y_d; z_q <= z_d; geom_q <= geom_i;
    end
  end

  assign valid_o = valid_q;
  assign x_o = x_q;
  assign y_o = y_q;
  assign z_o = z_q;
  assign geom_o = geom_q;
endmodule

/* sv/corov_test.sv */
// rotation into box frame, clamp and distance test, four register stages
module corov_test (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             en_i,
  input  logic             valid_i,
  input  corov_pkg::xy_t   x_i,
  input  corov_pkg::xy_t   y_i,
  input  corov_pkg::geom_t geom_i,
  output logic             valid_o,
  output logic             overlap_o
);
  localparam int TB = corov_pkg::TrigBits;
  localparam int PB = corov_pkg::ProdBits;
  localparam int LB = corov_pkg::LocBits;
  localparam int SB = corov_pkg::SqBits;
  localparam int F  = corov_pkg::TrigFracBits;
  localparam int RB = corov_pkg::RadBits;

  logic [3:0] valid_q;
  logic signed [corov_pkg::XyBits:0] cc, ss;
  logic signed [TB-1:0] c_d, s_d, c_q, s_q;
  corov_pkg::geom_t g1_q, g2_q;
  logic signed [PB-1:0] p_d [4];
  logic signed [PB-1:0] p_q [4];
  logic signed [LB-1:0] lx, ly, lmx, lmy, ex_d, ey_d, ex_q, ey_q;
  logic signed [PB:0] sx, sy;
  logic [RB-1:0] rad3_q;
  logic [SB-1:0] d2_d, r2_d, d2_q, r2_q;

  function automatic logic signed [TB-1:0] sat(input logic signed [corov_pkg::XyBits:0] v);
    logic signed [corov_pkg::XyBits:0] hi, lo;
    hi = (corov_pkg::XyBits+1)'((1 << F) - 1);
    lo = -(corov_pkg::XyBits+1)'(1 << F);
    if (v > hi) return TB'(hi);
    if (v < lo) return TB'(lo);
    return TB'(v);
  endfunction

  // quadrant map and saturation
  always_comb begin
    case (geom_i.quad)
      2'd0: begin cc = x_i;   ss = y_i;  end
      2'd1: begin cc = -y_i;  ss = x_i;  end
      2'd2: begin cc = -x_i;  ss = -y_i; end
      default: begin cc = y_i; ss = -x_i; end
    endcase
    c_d = sat(cc);
    s_d = sat(ss);
  end

  // four products
  always_comb begin
    p_d[0] = PB'(g1_q.dx * c_q);
    p_d[1] = PB'(g1_q.dy * s_q);
    p_d[2] = PB'(g1_q.dy * c_q);
    p_d[3] = PB'(g1_q.dx * s_q);
  end

  // sums, quarter rounding, clamp
  always_comb begin
    sx = (PB+1)'(p_q[0]) + (PB+1)'(p_q[1]) + (PB+1)'(1 << (F - 3));
    sy = (PB+1)'(p_q[2]) - (PB+1)'(p_q[3]) + (PB+1)'(1 << (F - 3));
    lx = LB'(sx >>> (F - 2));
    ly = LB'(sy >>> (F - 2));
    lmx = LB'({g2_q.w, 1'b0});
    lmy = LB'({g2_q.h, 1'b0});
    if (lx > lmx) ex_d = lx - lmx;
    else if (lx < -lmx) ex_d = lx + lmx;
    else ex_d = '0;
    if (ly > lmy) ey_d = ly - lmy;
    else if (ly < -lmy) ey_d = ly + lmy;
    else ey_d = '0;
  end

  // squares
  always_comb begin
    d2_d = SB'(ex_q * ex_q) + SB'(ey_q * ey_q);
    r2_d = SB'(rad3_q * rad3_q) << 4;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else if (en_i) begin
      valid_q <= {valid_q[2:0], valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      c_q <= c_d; s_q <= s_d; g1_q <= geom_i;
      p_q <= p_d; g2_q <= g1_q;
      ex_q <= ex_d; ey_q <= ey_d; rad3_q <= g2_q.rad;
      d2_q <= d2_d; r2_q <= r2_d;
    end
  end

  assign valid_o = valid_q[3];
  assign overlap_o = (d2_q <= r2_q);
endmodule

/* sv/circle_oriented_rect_overlap_unit.sv */
// Circle versus rotated rectangle overlap test. One beat in, one beat out, one pair
// accepted per clock at full throughput while the output is not stalled. The pipe is
// an input register, sixteen CORDIC rotation stages that produce cosine and sine of
// the box angle, then quadrant mapping, products, rounding with clamp,
// square-and-compare stages and the output register.
// The whole pipe advances when the output register is empty or being taken, so a
// stall on the master side holds every stage.
module circle_oriented_rect_overlap_unit (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  // circle_x, circle_y, circle_radius, box_x, box_y, box_width, box_height, box_angle
  input  logic [127:0] s_axis_tdata,
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // overlap
  output logic [7:0]   m_axis_tdata
);
  localparam int N = corov_pkg::CordicSteps;
  localparam int CB = corov_pkg::CoordBits;

  logic en, v_q, ov;
  corov_pkg::geom_t g_q;
  corov_pkg::z_t z0_q;
  logic [N:0] vc;
  corov_pkg::xy_t xc [N+1];
  corov_pkg::xy_t yc [N+1];
  corov_pkg::z_t  zc [N+1];
  corov_pkg::geom_t gc [N+1];
  logic out_v_q, out_d_q, tv;
  logic signed [CB-1:0] cx, cy, bx, by;
  logic [15:0] ang;

  assign en = !out_v_q || m_axis_tready;
  assign s_axis_tready = en;

  // field unpacking
  assign cx  = s_axis_tdata[15:0];
  assign cy  = s_axis_tdata[31:16];
  assign bx  = s_axis_tdata[62:47];
  assign by  = s_axis_tdata[78:63];
  assign ang = s_axis_tdata[124:109];

  // input register: offsets and cordic angle
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= 1'b0;
    end else if (en) begin
      v_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      g_q.dx   <= corov_pkg::diff_t'(cx) - corov_pkg::diff_t'(bx);
      g_q.dy   <= corov_pkg::diff_t'(cy) - corov_pkg::diff_t'(by);
      g_q.rad  <= s_axis_tdata[46:32];
      g_q.w    <= s_axis_tdata[93:79];
      g_q.h    <= s_axis_tdata[108:94];
      g_q.quad <= ang[15:14];
      z0_q     <= corov_pkg::z_t'({ang[13:0], 16'h0000});
    end
  end

  assign vc[0] = v_q;
  assign xc[0] = corov_pkg::CordicX0;
  assign yc[0] = '0;
  assign zc[0] = z0_q;
  assign gc[0] = g_q;

  // cordic chain
  for (genvar i = 0; i < N; i++) begin : g_cordic
    corov_cordic_stage u_stage (
      .clk_i, .rst_ni, .en_i(en), .step_i(corov_pkg::StepBits'(i)),
      .valid_i(vc[i]), .x_i(xc[i]), .y_i(yc[i]), .z_i(zc[i]), .geom_i(gc[i]),
      .valid_o(vc[i+1]), .x_o(xc[i+1]), .y_o(yc[i+1]), .z_o(zc[i+1]), .geom_o(gc[i+1])
    );
  end

  corov_test u_test (
    .clk_i, .rst_ni, .en_i(en),
    .valid_i(vc[N]), .x_i(xc[N]), .y_i(yc[N]), .geom_i(gc[N]),
    .valid_o(tv), .overlap_o(ov)
  );

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q <= 1'b0;
    end else if (en) begin
      out_v_q <= tv;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      out_d_q <= ov;
    end
  end

  assign m_axis_tvalid = out_v_q;
  assign m_axis_tdata  = {7'b0, out_d_q};
endmodule

/* sv/corov_checker.sv */
// port-level checks
module corov_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       s_axis_tready,
  input logic       m_axis_tvalid,
  input logic       m_axis_tready,
  input logic [7:0] m_axis_tdata
);
  // stalled result holds
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("result changed under stall");
  // upper pad bits zero
  a_pad: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> m_axis_tdata[7:1] == 7'd0)
    else $error("pad bits set");
  // ready whenever output free
  a_rdy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !m_axis_tvalid |-> s_axis_tready)
    else $error("input stalled with empty output");
endmodule

bind circle_oriented_rect_overlap_unit corov_checker u_corov_checker (
  .clk_i, .rst_ni, .s_axis_tready,
  .m_axis_tvalid, .m_axis_tready, .m_axis_tdata
);

/* sim/circle_oriented_rect_overlap_unit_test.sv */
module circle_oriented_rect_overlap_unit_test;

  logic         clk_i = 1'b0;
  logic         rst_ni = 1'b0;
  logic         s_axis_tvalid = 1'b0;
  logic         s_axis_tready;
  // circle_x, circle_y, circle_radius, box_x, box_y, box_width, box_height, box_angle
  logic [127:0] s_axis_tdata = '0;
  logic         m_axis_tvalid;
  logic         m_axis_tready = 1'b0;
  // overlap
  logic [7:0]   m_axis_tdata;

  logic [127:0] pending_pairs[$];
  logic         overlap_q[$];
  int           fails = 0;
  int           cycles = 0;
  int           accepted = 0;
  int           burst_left = 0;
  int           gap_left = 0;
  int           hold_left = 0;
  int           stall_mode = 0;
  bit           hold_done = 0;

  circle_oriented_rect_overlap_unit dut (
    .clk_i, .rst_ni, .s_axis_tvalid, .s_axis_tready, .s_axis_tdata,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata
  );

  always #1 clk_i = ~clk_i;

  function automatic logic [127:0] pack_pair(int cx, int cy, int r, int bx, int by,
                                             int w, int h, int a);
    logic [127:0] d;
    d = '0;
    d[15:0]    = cx[15:0];
    d[31:16]   = cy[15:0];
    d[46:32]   = r[14:0];
    d[62:47]   = bx[15:0];
    d[78:63]   = by[15:0];
    d[93:79]   = w[14:0];
    d[108:94]  = h[14:0];
    d[124:109] = a[15:0];
    return d;
  endfunction

  // cosine and sine of the box angle, Q1.15, via 16-step cordic
  function automatic void box_cos_sin(logic [15:0] ang, output longint c, output longint s);
    longint x, y, z, xs, ys, cc, ss;
    logic [31:0] t;
    x = (64'd2608131496 + (64'd1 << 16)) >> 17;
    y = 0;
    z = longint'(ang[13:0]) << 16;
    for (int i = 0; i < 16; i++) begin
      xs = x >>> i;
      ys = y >>> i;
      t = corov_pkg::atan_turn(i);
      if (z >= 0) begin
        x = x - ys; y = y + xs; z = z - longint'(t);
      end else begin
        x = x + ys; y = y - xs; z = z + longint'(t);
      end
    end
    case (ang[15:14])
      2'd0: begin cc = x;  ss = y;  end
      2'd1: begin cc = -y; ss = x;  end
      2'd2: begin cc = -x; ss = -y; end
      default: begin cc = y; ss = -x; end
    endcase
    c = (cc > 32767) ? 32767 : (cc < -32768) ? -32768 : cc;
    s = (ss > 32767) ? 32767 : (ss < -32768) ? -32768 : ss;
  endfunction

  function automatic logic circle_hits_box(logic [127:0] d);
    longint c, s, dx, dy, lx, ly, ex, ey, lw, lh, r;
    box_cos_sin(d[124:109], c, s);
    dx = longint'($signed(d[15:0])) - longint'($signed(d[62:47]));
    dy = longint'($signed(d[31:16])) - longint'($signed(d[78:63]));
    r  = longint'(d[46:32]);
    lw = 2 * longint'(d[93:79]);
    lh = 2 * longint'(d[108:94]);
    lx = (dx * c + dy * s + 4096) >>> 13;
    ly = (dy * c - dx * s + 4096) >>> 13;
    ex = lx - ((lx > lw) ? lw : (lx < -lw) ? -lw : lx);
    ey = ly - ((ly > lh) ? lh : (ly < -lh) ? -lh : ly);
    return (ex * ex + ey * ey) <= (r * r * 16);
  endfunction

  // sender: bursts and gaps; predict on each accepted beat
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (s_axis_tvalid && s_axis_tready) begin
        overlap_q.push_back(circle_hits_box(s_axis_tdata));
        accepted++;
      end
      if (!s_axis_tvalid || s_axis_tready) begin
        if (gap_left > 0 || pending_pairs.size() == 0) begin
          if (gap_left > 0) gap_left--;
          s_axis_tvalid <= 1'b0;
        end else begin
          s_axis_tvalid <= 1'b1;
          s_axis_tdata <= pending_pairs.pop_front();
          if (burst_left > 0) burst_left--;
          else begin
            burst_left = $urandom_range(0, 40);
            gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
          end
        end
      end
    end
  end

  // receiver: own stall pattern plus one long hold-off
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (!hold_done && accepted >= 400) begin
        hold_done = 1;
        hold_left = 300;
      end
      if ($urandom_range(0, 63) == 0) stall_mode = $urandom_range(0, 2);
      if (hold_left > 0) begin
        hold_left--;
        m_axis_tready <= 1'b0;
      end else if (stall_mode == 0) begin
        m_axis_tready <= 1'b1;
      end else begin
        m_axis_tready <= ($urandom_range(0, stall_mode) == 0);
      end
    end
  end

  // checker
  always @(posedge clk_i) begin
    logic exp_ov;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (overlap_q.size() == 0) begin
        $display("%0t unexpected beat: expected none, actual %h", $time, m_axis_tdata);
        fails++;
      end else begin
        exp_ov = overlap_q.pop_front();
        if (m_axis_tdata !== {7'b0, exp_ov}) begin
          $display("%0t overlap mismatch: expected %h, actual %h", $time,
                   {7'b0, exp_ov}, m_axis_tdata);
          fails++;
        end
      end
    end
  end

  // watchdog
  always @(posedge clk_i) begin
    cycles++;
    if (cycles > 200000) begin
      $display("circle_oriented_rect_overlap_unit_test NOT OK");
      $finish;
    end
  end

  initial begin
    int bx, by, r, w, h, a;
    // directed pairs
    pending_pairs.push_back(pack_pair(0, 0, 0, 0, 0, 0, 0, 0));
    pending_pairs.push_back(pack_pair(1, 0, 0, 0, 0, 0, 0, 0));
    pending_pairs.push_back(pack_pair(10, 0, 0, 0, 0, 20, 0, 0));
    pending_pairs.push_back(pack_pair(0, 10, 0, 0, 0, 0, 20, 16384));
    pending_pairs.push_back(pack_pair(15, 0, 5, 0, 0, 20, 20, 0));
    pending_pairs.push_back(pack_pair(16, 0, 5, 0, 0, 20, 20, 0));
    pending_pairs.push_back(pack_pair(0, 15, 5, 0, 0, 20, 20, 32768));
    pending_pairs.push_back(pack_pair(-15, 0, 5, 0, 0, 20, 20, 49152));
    pending_pairs.push_back(pack_pair(20, 20, 8, 0, 0, 20, 20, 8192));
    pending_pairs.push_back(pack_pair(30, 30, 1, 0, 0, 40, 4, 65535));
    pending_pairs.push_back(pack_pair(32767, 32767, 32767, -32768, -32768, 32767, 32767, 0));
    pending_pairs.push_back(pack_pair(-32768, -32768, 0, 32767, 32767, 0, 0, 24576));
    pending_pairs.push_back(pack_pair(32767, -32768, 32767, -32768, 32767, 0, 0, 40960));
    pending_pairs.push_back(pack_pair(-32768, 32767, 100, 32767, -32768, 32767, 0, 57344));
    pending_pairs.push_back(pack_pair(0, 0, 32767, 0, 0, 32767, 32767, 65535));
    pending_pairs.push_back(pack_pair(100, -50, 0, 100, -50, 0, 0, 12345));
    pending_pairs.push_back(pack_pair(-7, 3, 2, -7, 3, 0, 9, 1));
    pending_pairs.push_back(pack_pair(500, 500, 10, 0, 0, 1000, 10, 8192));
    // random pairs, mostly near contact
    for (int i = 0; i < 1250; i++) begin
      if ($urandom_range(0, 3) == 0) begin
        pending_pairs.push_back({3'b0, 125'({$urandom, $urandom, $urandom, $urandom})});
      end else begin
        bx = $urandom_range(0, 65535) - 32768;
        by = $urandom_range(0, 65535) - 32768;
        r  = $urandom_range(0, 300);
        w  = $urandom_range(0, 600);
        h  = $urandom_range(0, 600);
        a  = $urandom_range(0, 65535);
        pending_pairs.push_back(pack_pair(bx + $urandom_range(0, 1400) - 700,
                                          by + $urandom_range(0, 1400) - 700,
                                          r, bx, by, w, h, a));
      end
    end
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    while (pending_pairs.size() != 0 || s_axis_tvalid || overlap_q.size() != 0)
      @(posedge clk_i);
    repeat (40) @(posedge clk_i);
    if (fails == 0) begin
      $display("circle_oriented_rect_overlap_unit_test OK");
    end else begin
      $display("circle_oriented_rect_overlap_unit_test NOT OK");
    end
    $finish;
  end
endmodule

/* sim.f */
sv/corov_pkg.sv
sv/corov_cordic_stage.sv
sv/corov_test.sv
sv/circle_oriented_rect_overlap_unit.sv
sv/corov_checker.sv
sim/circle_oriented_rect_overlap_unit_test.sv
